[rtl/fsum_pkg.sv]
// ----------------------------------------------------------------------------
// fsum_pkg
// Shared widths, command codes, status codes and item types for the
// fraction sum core.
// ----------------------------------------------------------------------------
package fsum_pkg;

  localparam int TERM_BITS = 16;
  localparam int ACC_BITS  = 48;

  localparam int MAG_BITS  = TERM_BITS + 1;
  localparam int LCM_BITS  = ACC_BITS - 1;
  localparam int UNIT_BITS = (ACC_BITS > MAG_BITS) ? ACC_BITS : MAG_BITS;
  localparam int PROD_BITS = UNIT_BITS + MAG_BITS;

  localparam int GCD_SHIFT_BITS = $clog2(UNIT_BITS);
  localparam int DIV_CNT_BITS   = $clog2(UNIT_BITS + 1);
  localparam int MUL_CNT_BITS   = $clog2(MAG_BITS + 1);

  localparam logic [PROD_BITS-1:0] ACC_HI      = PROD_BITS'({(ACC_BITS-1){1'b1}});
  localparam logic [PROD_BITS-1:0] ACC_NEG_LIM = ACC_HI + PROD_BITS'(1);

  typedef logic [3:0] op_t;

  localparam op_t OP_NONE      = 4'd0;
  localparam op_t OP_LOAD      = 4'd1;
  localparam op_t OP_GCD_TERM  = 4'd2;
  localparam op_t OP_DIV_GROW  = 4'd3;
  localparam op_t OP_DIV_LCM   = 4'd4;
  localparam op_t OP_MUL_LCM   = 4'd5;
  localparam op_t OP_MUL_SUM   = 4'd6;
  localparam op_t OP_MUL_TERM  = 4'd7;
  localparam op_t OP_ADD       = 4'd8;
  localparam op_t OP_DIV_FINAL = 4'd9;
  localparam op_t OP_GCD_FINAL = 4'd10;
  localparam op_t OP_DIV_REM   = 4'd11;
  localparam op_t OP_DIV_DEN   = 4'd12;
  localparam op_t OP_RESULT    = 4'd13;

  typedef logic [1:0] status_code_t;

  localparam status_code_t ST_OK       = 2'd0;
  localparam status_code_t ST_ZERO_DEN = 2'd1;
  localparam status_code_t ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [TERM_BITS-1:0] numerator;
    logic signed [TERM_BITS-1:0] denominator;
    logic                        last_term;
  } term_t;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] sum_numerator;
    logic        [LCM_BITS-1:0] common_denominator;
    logic signed [ACC_BITS-1:0] whole_part;
    logic signed [ACC_BITS-1:0] remainder_numerator;
    logic        [LCM_BITS-1:0] remainder_denominator;
    status_code_t               status;
  } result_t;

  typedef struct packed {
    op_t  op;
    logic go;
    logic latch;
  } dp_cmd_t;

  typedef struct packed {
    logic op_done;
    logic err;
    logic last;
    logic rem_zero;
  } dp_status_t;

endpackage

[rtl/fsum_gcd.sv]
// ----------------------------------------------------------------------------
// fsum_gcd
// Binary gcd unit, one subtract or shift step per cycle. Both operands
// must be nonzero.
// ----------------------------------------------------------------------------
module fsum_gcd import fsum_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [UNIT_BITS-1:0] a_in,
  input  logic [UNIT_BITS-1:0] b_in,
  output logic                 done,
  output logic [UNIT_BITS-1:0] g
);

  logic                      active;
  logic [UNIT_BITS-1:0]      a;
  logic [UNIT_BITS-1:0]      b;
  logic [GCD_SHIFT_BITS-1:0] k;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
      end else if (active && (a == b)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a <= a_in;
      b <= b_in;
      k <= '0;
    end else if (active) begin
      if (a == b) begin
        g <= a << k;
      end else if (!a[0] && !b[0]) begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + GCD_SHIFT_BITS'(1);
      end else if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a > b) begin
        a <= (a - b) >> 1;
      end else begin
        b <= (b - a) >> 1;
      end
    end
  end

endmodule

[rtl/fsum_div.sv]
// ----------------------------------------------------------------------------
// fsum_div
// Unsigned restoring divider, one quotient bit per cycle. The divisor
// must be nonzero.
// ----------------------------------------------------------------------------
module fsum_div import fsum_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [UNIT_BITS-1:0] dividend,
  input  logic [UNIT_BITS-1:0] divisor,
  output logic                 done,
  output logic [UNIT_BITS-1:0] quotient,
  output logic [UNIT_BITS-1:0] remainder
);

  logic                    active;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [UNIT_BITS-1:0]    dsr;
  logic [UNIT_BITS:0]      shifted;
  logic [UNIT_BITS:0]      trial;

  assign shifted = {remainder, quotient[UNIT_BITS-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
      end else if (active && (cnt == DIV_CNT_BITS'(1))) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      remainder <= '0;
      quotient  <= dividend;
      dsr       <= divisor;
      cnt       <= DIV_CNT_BITS'(UNIT_BITS);
    end else if (active) begin
      cnt <= cnt - DIV_CNT_BITS'(1);
      if (!trial[UNIT_BITS]) begin
        remainder <= trial[UNIT_BITS-1:0];
        quotient  <= {quotient[UNIT_BITS-2:0], 1'b1};
      end else begin
        remainder <= shifted[UNIT_BITS-1:0];
        quotient  <= {quotient[UNIT_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/fsum_dp.sv]
// ----------------------------------------------------------------------------
// fsum_dp
// Datapath: run registers, term registers, shift-add multiplier, gcd and
// divider units and the result register, driven by controller commands.
// ----------------------------------------------------------------------------
module fsum_dp import fsum_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  term_t      item,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       strobe,
  output result_t    result
);

  // run state
  logic signed [ACC_BITS-1:0] run_sum;
  logic        [LCM_BITS-1:0] run_lcm;
  logic                       ovf_seen;
  logic                       zden_seen;

  // term registers
  logic                 last;
  logic [MAG_BITS-1:0]  ud;
  logic                 n_neg;
  logic [MAG_BITS-1:0]  n_mag;
  logic [MAG_BITS-1:0]  grow;
  logic [UNIT_BITS-1:0] lcm_q;
  logic [LCM_BITS-1:0]  new_lcm;
  logic signed [ACC_BITS-1:0] sc_sum;
  logic signed [ACC_BITS-1:0] sc_term;
  logic                 term_ovf;

  // final registers
  logic [ACC_BITS-1:0] whole_mag;
  logic [LCM_BITS-1:0] rem_mag;
  logic [LCM_BITS-1:0] rem_red;
  logic [LCM_BITS-1:0] rden;

  // input conditioning
  logic signed [MAG_BITS-1:0] d_ext;
  logic signed [MAG_BITS-1:0] n_ext;
  logic signed [MAG_BITS-1:0] n_adj;
  logic                       d_neg;

  assign d_ext = MAG_BITS'(item.denominator);
  assign n_ext = MAG_BITS'(item.numerator);
  assign d_neg = d_ext[MAG_BITS-1];
  assign n_adj = d_neg ? -n_ext : n_ext;

  logic                sum_neg;
  logic [ACC_BITS-1:0] sum_mag;

  assign sum_neg = run_sum[ACC_BITS-1];
  assign sum_mag = sum_neg ? ACC_BITS'(-run_sum) : ACC_BITS'(run_sum);

  // unit operand selection
  logic [UNIT_BITS-1:0] ga, gb, g_val;
  logic [UNIT_BITS-1:0] dn, dd, div_q, div_r;
  logic [UNIT_BITS-1:0] ma;
  logic [MAG_BITS-1:0]  mb;
  logic                 gcd_go, div_go, mul_go;
  logic                 gcd_done, div_done;

  always_comb begin
    ga = '0;
    gb = '0;
    dn = '0;
    dd = '0;
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_GCD_TERM: begin
        ga = UNIT_BITS'(run_lcm);
        gb = UNIT_BITS'(ud);
      end
      OP_GCD_FINAL: begin
        ga = UNIT_BITS'(rem_mag);
        gb = UNIT_BITS'(run_lcm);
      end
      OP_DIV_GROW: begin
        dn = UNIT_BITS'(ud);
        dd = g_val;
      end
      OP_DIV_LCM, OP_DIV_DEN: begin
        dn = UNIT_BITS'(run_lcm);
        dd = g_val;
      end
      OP_DIV_FINAL: begin
        dn = UNIT_BITS'(sum_mag);
        dd = UNIT_BITS'(run_lcm);
      end
      OP_DIV_REM: begin
        dn = UNIT_BITS'(rem_mag);
        dd = g_val;
      end
      OP_MUL_LCM: begin
        ma = UNIT_BITS'(run_lcm);
        mb = grow;
      end
      OP_MUL_SUM: begin
        ma = UNIT_BITS'(sum_mag);
        mb = grow;
      end
      OP_MUL_TERM: begin
        ma = lcm_q;
        mb = n_mag;
      end
      default: begin
      end
    endcase
  end

  assign gcd_go = cmd.go && ((cmd.op == OP_GCD_TERM) || (cmd.op == OP_GCD_FINAL));
  assign div_go = cmd.go && ((cmd.op == OP_DIV_GROW) || (cmd.op == OP_DIV_LCM) ||
                             (cmd.op == OP_DIV_FINAL) || (cmd.op == OP_DIV_REM) ||
                             (cmd.op == OP_DIV_DEN));
  assign mul_go = cmd.go && ((cmd.op == OP_MUL_LCM) || (cmd.op == OP_MUL_SUM) ||
                             (cmd.op == OP_MUL_TERM));

  fsum_gcd u_gcd (
    .clk  (clk),
    .rst  (rst),
    .go   (gcd_go),
    .a_in (ga),
    .b_in (gb),
    .done (gcd_done),
    .g    (g_val)
  );

  fsum_div u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (dn),
    .divisor   (dd),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // shift-add multiplier, one bit of the narrow operand per cycle
  logic                    mul_active;
  logic                    mul_done;
  logic [MUL_CNT_BITS-1:0] mul_cnt;
  logic [PROD_BITS-1:0]    mul_acc;
  logic [PROD_BITS-1:0]    mul_a;
  logic [MAG_BITS-1:0]     mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_active <= 1'b0;
      mul_done   <= 1'b0;
    end else begin
      mul_done <= 1'b0;
      if (mul_go) begin
        mul_active <= 1'b1;
      end else if (mul_active && (mul_cnt == MUL_CNT_BITS'(1))) begin
        mul_active <= 1'b0;
        mul_done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_go) begin
      mul_acc <= '0;
      mul_a   <= PROD_BITS'(ma);
      mul_b   <= mb;
      mul_cnt <= MUL_CNT_BITS'(MAG_BITS);
    end else if (mul_active) begin
      if (mul_b[0]) begin
        mul_acc <= mul_acc + mul_a;
      end
      mul_a   <= mul_a << 1;
      mul_b   <= mul_b >> 1;
      mul_cnt <= mul_cnt - MUL_CNT_BITS'(1);
    end
  end

  // accumulate
  logic signed [ACC_BITS:0] total;
  logic                     add_ovf;

  assign total   = (ACC_BITS+1)'(sc_sum) + (ACC_BITS+1)'(sc_term);
  assign add_ovf = total[ACC_BITS] ^ total[ACC_BITS-1];

  // result assembly
  result_t result_next;
  logic    rem_neg;

  assign rem_neg = sum_neg && (whole_mag == '0);

  always_comb begin
    result_next.status = zden_seen ? ST_ZERO_DEN : (ovf_seen ? ST_OVERFLOW : ST_OK);
    if (zden_seen || ovf_seen) begin
      result_next.sum_numerator         = '0;
      result_next.common_denominator    = LCM_BITS'(1);
      result_next.whole_part            = '0;
      result_next.remainder_numerator   = '0;
      result_next.remainder_denominator = LCM_BITS'(1);
    end else begin
      result_next.sum_numerator      = run_sum;
      result_next.common_denominator = run_lcm;
      result_next.whole_part         = sum_neg ? -whole_mag : whole_mag;
      if (rem_mag == '0) begin
        result_next.remainder_numerator   = '0;
        result_next.remainder_denominator = LCM_BITS'(1);
      end else begin
        result_next.remainder_numerator   = rem_neg ? -ACC_BITS'(rem_red)
                                                    : ACC_BITS'(rem_red);
        result_next.remainder_denominator = rden;
      end
    end
  end

  // run state and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum   <= '0;
      run_lcm   <= LCM_BITS'(1);
      ovf_seen  <= 1'b0;
      zden_seen <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.latch) begin
        case (cmd.op)
          OP_LOAD: begin
            if (item.denominator == '0) begin
              zden_seen <= 1'b1;
            end
          end
          OP_ADD: begin
            if (term_ovf || add_ovf) begin
              ovf_seen <= 1'b1;
            end else begin
              run_sum <= total[ACC_BITS-1:0];
              run_lcm <= new_lcm;
            end
          end
          OP_RESULT: begin
            strobe    <= 1'b1;
            run_sum   <= '0;
            run_lcm   <= LCM_BITS'(1);
            ovf_seen  <= 1'b0;
            zden_seen <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // term and final registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      case (cmd.op)
        OP_LOAD: begin
          last     <= item.last_term;
          ud       <= d_neg ? MAG_BITS'(-d_ext) : MAG_BITS'(d_ext);
          n_neg    <= n_adj[MAG_BITS-1];
          n_mag    <= n_adj[MAG_BITS-1] ? MAG_BITS'(-n_adj) : MAG_BITS'(n_adj);
          term_ovf <= 1'b0;
        end
        OP_DIV_GROW: grow <= div_q[MAG_BITS-1:0];
        OP_DIV_LCM:  lcm_q <= div_q;
        OP_MUL_LCM: begin
          new_lcm  <= mul_acc[LCM_BITS-1:0];
          term_ovf <= term_ovf | (mul_acc > ACC_HI);
        end
        OP_MUL_SUM: begin
          sc_sum   <= sum_neg ? -mul_acc[ACC_BITS-1:0] : mul_acc[ACC_BITS-1:0];
          term_ovf <= term_ovf | (mul_acc > (sum_neg ? ACC_NEG_LIM : ACC_HI));
        end
        OP_MUL_TERM: begin
          sc_term  <= n_neg ? -mul_acc[ACC_BITS-1:0] : mul_acc[ACC_BITS-1:0];
          term_ovf <= term_ovf | (mul_acc > (n_neg ? ACC_NEG_LIM : ACC_HI));
        end
        OP_DIV_FINAL: begin
          whole_mag <= div_q[ACC_BITS-1:0];
          rem_mag   <= div_r[LCM_BITS-1:0];
        end
        OP_DIV_REM: rem_red <= div_q[LCM_BITS-1:0];
        OP_DIV_DEN: rden <= div_q[LCM_BITS-1:0];
        OP_RESULT:  result <= result_next;
        default: begin
        end
      endcase
    end
  end

  assign status.op_done  = gcd_done | div_done | mul_done;
  assign status.err      = zden_seen | ovf_seen;
  assign status.last     = last;
  assign status.rem_zero = (div_r == '0);

`ifndef NO_ASSERTIONS
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result strobe held longer than one cycle");

  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (run_lcm == LCM_BITS'(1)) && (run_sum == '0) && !ovf_seen && !zden_seen)
    else $error("run state not cleared after result");

  a_lcm_nonzero: assert property (@(posedge clk) disable iff (rst)
    run_lcm != '0)
    else $error("running denominator is zero");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({gcd_done, div_done, mul_done}))
    else $error("more than one arithmetic unit finished at once");
`endif

endmodule

[rtl/fsum_ctrl.sv]
// ----------------------------------------------------------------------------
// fsum_ctrl
// Sequencer for the fraction sum core: steps one term through gcd,
// divisions, multiplies and the add, then the final mixed-number pass.
// ----------------------------------------------------------------------------
module fsum_ctrl import fsum_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output logic       busy,
  output dp_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_GCD_TERM  = 4'd2;
  localparam logic [3:0] S_DIV_GROW  = 4'd3;
  localparam logic [3:0] S_DIV_LCM   = 4'd4;
  localparam logic [3:0] S_MUL_LCM   = 4'd5;
  localparam logic [3:0] S_MUL_SUM   = 4'd6;
  localparam logic [3:0] S_MUL_TERM  = 4'd7;
  localparam logic [3:0] S_ADD       = 4'd8;
  localparam logic [3:0] S_END       = 4'd9;
  localparam logic [3:0] S_DIV_FINAL = 4'd10;
  localparam logic [3:0] S_GCD_FINAL = 4'd11;
  localparam logic [3:0] S_DIV_REM   = 4'd12;
  localparam logic [3:0] S_DIV_DEN   = 4'd13;
  localparam logic [3:0] S_RESULT    = 4'd14;

  logic [3:0] state, state_next;
  logic       launched, launched_next;
  logic       unit_op;
  op_t        unit_code;
  logic [3:0] unit_after;

  always_comb begin
    state_next    = state;
    launched_next = launched;
    cmd.op        = OP_NONE;
    cmd.go        = 1'b0;
    cmd.latch     = 1'b0;
    unit_op       = 1'b0;
    unit_code     = OP_NONE;
    unit_after    = S_IDLE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          cmd.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = status.err ? S_END : S_GCD_TERM;
      S_GCD_TERM: begin
        unit_op    = 1'b1;
        unit_code  = OP_GCD_TERM;
        unit_after = S_DIV_GROW;
      end
      S_DIV_GROW: begin
        unit_op    = 1'b1;
        unit_code  = OP_DIV_GROW;
        unit_after = S_DIV_LCM;
      end
      S_DIV_LCM: begin
        unit_op    = 1'b1;
        unit_code  = OP_DIV_LCM;
        unit_after = S_MUL_LCM;
      end
      S_MUL_LCM: begin
        unit_op    = 1'b1;
        unit_code  = OP_MUL_LCM;
        unit_after = S_MUL_SUM;
      end
      S_MUL_SUM: begin
        unit_op    = 1'b1;
        unit_code  = OP_MUL_SUM;
        unit_after = S_MUL_TERM;
      end
      S_MUL_TERM: begin
        unit_op    = 1'b1;
        unit_code  = OP_MUL_TERM;
        unit_after = S_ADD;
      end
      S_ADD: begin
        cmd.op     = OP_ADD;
        cmd.latch  = 1'b1;
        state_next = S_END;
      end
      S_END: begin
        if (!status.last) begin
          state_next = S_IDLE;
        end else if (status.err) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_DIV_FINAL;
        end
      end
      S_DIV_FINAL: begin
        unit_op    = 1'b1;
        unit_code  = OP_DIV_FINAL;
        unit_after = status.rem_zero ? S_RESULT : S_GCD_FINAL;
      end
      S_GCD_FINAL: begin
        unit_op    = 1'b1;
        unit_code  = OP_GCD_FINAL;
        unit_after = S_DIV_REM;
      end
      S_DIV_REM: begin
        unit_op    = 1'b1;
        unit_code  = OP_DIV_REM;
        unit_after = S_DIV_DEN;
      end
      S_DIV_DEN: begin
        unit_op    = 1'b1;
        unit_code  = OP_DIV_DEN;
        unit_after = S_RESULT;
      end
      S_RESULT: begin
        cmd.op     = OP_RESULT;
        cmd.latch  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    // multi-cycle unit: launch once, latch when it reports done
    if (unit_op) begin
      cmd.op = unit_code;
      if (!launched) begin
        cmd.go        = 1'b1;
        launched_next = 1'b1;
      end else if (status.op_done) begin
        cmd.latch     = 1'b1;
        launched_next = 1'b0;
        state_next    = unit_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

  assign busy = (state != S_IDLE);

`ifndef NO_ASSERTIONS
  a_go_latch_apart: assert property (@(posedge clk) disable iff (rst)
    !(cmd.go && cmd.latch))
    else $error("unit launched and latched in the same cycle");

  a_go_then_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.go |=> launched && !cmd.go)
    else $error("unit launched twice");

  a_idle_not_launched: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !launched)
    else $error("launch flag left set in idle");
`endif

endmodule

[rtl/fraction_sum_mixed_number_core.sv]
// ----------------------------------------------------------------------------
// fraction_sum_mixed_number_core
// Sums a run of signed fractions over their least common denominator and
// reports the total as a mixed number on the last item of the run.
//
//   channel  direction  handshake            payload
//   item     in         start, busy          item   (term_t)
//   result   out        done (one cycle)     result (result_t)
//
// A term runs from accept to the next accept through one binary-gcd run, two
// divisions and three multiplies, plus control states; a term of a run
// already in error skips them and goes straight to the end state.
// The last item adds one division and, for a nonzero remainder, one gcd run
// and two more divisions; a run in error skips them all. done is registered
// from the result state that follows the last one.
// Synchronous reset clears the run to sum 0 over denominator 1.
// busy is high while an item is at work; results are never held off.
// ----------------------------------------------------------------------------
module fraction_sum_mixed_number_core import fsum_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  term_t   item,
  output logic    done,
  output result_t result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  fsum_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  fsum_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .strobe (done),
    .result (result)
  );

endmodule
